// ===== rtl/tcw_pkg.sv =====
// Shared types and constants of the text console cell writer.
package tcw_pkg;

   localparam logic [7:0] CHAR_NL       = 8'h0A;
   localparam logic [7:0] CHAR_BS       = 8'h08;
   localparam logic [7:0] CHAR_E        = 8'h45;
   localparam logic [7:0] CHAR_SPACE    = 8'h20;
   localparam logic [7:0] ATTR_DEFAULT  = 8'h0F;
   localparam logic [7:0] ATTR_ERR_RST  = 8'hF4;

   localparam int         CSR_IDX_W      = 4;
   localparam logic [3:0] CSR_TEXT_ATTR  = 4'd0;
   localparam logic [3:0] CSR_ERROR_ATTR = 4'd1;

   typedef enum logic [2:0] {
      CMD_WRITE = 3'd0,
      CMD_BACK  = 3'd1,
      CMD_LEFT  = 3'd2,
      CMD_RIGHT = 3'd3,
      CMD_CLEAR = 3'd4,
      CMD_READ  = 3'd5
   } cmd_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DISPATCH,
      S_NL_DIV,
      S_NL_ADD,
      S_NL_SUB,
      S_INC,
      S_CP_RD,
      S_CP_WR,
      S_RD_ISSUE,
      S_RD_TAKE,
      S_SCR_CHK,
      S_FILL,
      S_DONE
   } state_type;

   typedef enum logic [1:0] {
      CP_DEL,
      CP_INS,
      CP_SCROLL
   } cp_mode_type;

   typedef enum logic {
      FL_CLEAR,
      FL_ZERO
   } fill_mode_type;

   typedef enum logic {
      ALU_ADD,
      ALU_SUB
   } alu_op_type;

endpackage

// ===== rtl/text_console_cell_writer.sv =====
// Text console cell writer: cell store, cursor and command sequencer.
//
// Usage: one command item enters on the req_ channel (valid/stall) and
// exactly one result item leaves on the rsp_ channel. req_stall is high
// while a command is being worked; a result waiting in the output register
// does not hold off the next command, only its own completion.
// The csr_ channel (valid/ready, always ready) writes text_attr (index 0)
// and error_attr (index 1); write it only while the block is idle.
// Steps per item: a newline finds the column by repeated subtract of
// COLS in the shared adder; insert and delete move each shifted cell
// with one RAM read, then one write; a scroll copies (ROWS-1)*COLS
// cells up by one row and zeroes the last row; clear writes all
// ROWS*COLS cells. The single-port-pair cell RAM sets the walk rate.
// Reset: cursor to 0, attributes to their defaults, no result pending.
// Cell contents are undefined until written; clear before reading.
// When rsp_stall is high the result holds in its register.
module text_console_cell_writer import tcw_pkg::*; #(
   parameter int ROWS = 25,
   parameter int COLS = 80
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [2:0]                     req_command,
   input  logic [7:0]                     req_char_code,
   input  logic [7:0]                     req_col,
   input  logic [7:0]                     req_row,
   input  logic                           req_use_cursor,
   input  logic                           req_insert_mode,
   input  logic [7:0]                     req_tail_len,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [$clog2(ROWS*COLS)-1:0]   rsp_cursor_pos,
   output logic [7:0]                     rsp_read_char,
   output logic [7:0]                     rsp_read_attr,
   output logic                           rsp_coord_error,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [CSR_IDX_W-1:0]           csr_index,
   input  logic [7:0]                     csr_wdata
);

   localparam int CELLS = ROWS * COLS;
   localparam int AW    = $clog2(CELLS);
   localparam int PW    = $clog2(CELLS + 260);

   localparam logic [PW-1:0] CELLS_P    = PW'(CELLS);
   localparam logic [PW-1:0] COLS_P     = PW'(COLS);
   localparam logic [PW-1:0] LAST_P     = PW'(CELLS - 1);
   localparam logic [PW-1:0] SCR_BASE_P = PW'(CELLS - COLS);
   localparam logic [PW-1:0] SCR_LEN_P  = PW'(CELLS - COLS);
   localparam logic [PW-1:0] ONE_P      = PW'(1);

   state_type     state_ff, state_in;
   cmd_type       cmd_ff, cmd_in;
   logic [7:0]    ch_ff, ch_in;
   logic          ins_ff, ins_in;
   logic [7:0]    tail_ff, tail_in;
   logic          bad_ff, bad_in;
   logic [PW-1:0] pos_ff, pos_in;
   logic [PW-1:0] rem_ff, rem_in;
   logic [PW-1:0] src_ff, src_in;
   logic [PW-1:0] dst_ff, dst_in;
   logic [PW-1:0] cnt_ff, cnt_in;
   logic [AW-1:0] cursor_ff, cursor_in;
   cp_mode_type   cp_mode_ff, cp_mode_in;
   fill_mode_type fill_mode_ff, fill_mode_in;
   logic [7:0]    rd_char_ff, rd_char_in;
   logic [7:0]    rd_attr_ff, rd_attr_in;
   logic          err_ff, err_in;
   logic [7:0]    text_attr_ff, text_attr_in;
   logic [7:0]    error_attr_ff, error_attr_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [AW-1:0] rsp_cursor_ff, rsp_cursor_in;
   logic [7:0]    rsp_char_ff, rsp_char_in;
   logic [7:0]    rsp_attr_ff, rsp_attr_in;
   logic          rsp_err_ff, rsp_err_in;

   logic          ram_we;
   logic [AW-1:0] ram_waddr;
   logic [15:0]   ram_wdata;
   logic [AW-1:0] ram_raddr;
   logic [15:0]   ram_rdata;

   logic [PW-1:0] alu_a, alu_b, alu_res;
   alu_op_type    alu_op;
   logic          alu_ge;

   logic          accept;
   logic          rsp_free;
   logic          bad_req;
   logic [7:0]    plain_attr;
   logic [PW-1:0] bs_pos;
   logic          cnt_last;

   tcw_ram #(
      .WIDTH (16),
      .DEPTH (CELLS)
   ) u_cells (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   tcw_alu #(
      .W (PW)
   ) u_alu (
      .a   (alu_a),
      .b   (alu_b),
      .op  (alu_op),
      .res (alu_res),
      .ge  (alu_ge)
   );

   assign accept     = req_valid && (state_ff == S_IDLE);
   assign req_stall  = (state_ff != S_IDLE);
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign bad_req    = !req_use_cursor &&
                       ((9'(req_col) >= 9'(COLS)) || (req_row >= 8'(ROWS)));
   assign plain_attr = (text_attr_ff != 8'd0) ? text_attr_ff : ATTR_DEFAULT;
   assign bs_pos     = alu_ge ? alu_res : '0;
   assign cnt_last   = (cnt_ff == ONE_P);
   assign csr_ready  = 1'b1;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) state_in = S_DISPATCH;
         end
         S_DISPATCH: begin
            case (cmd_ff)
               CMD_WRITE: begin
                  if (bad_ff) state_in = S_DONE;
                  else if (ch_ff == CHAR_NL) state_in = S_NL_DIV;
                  else if (ch_ff == CHAR_BS || ins_ff) state_in = S_CP_RD;
                  else state_in = S_INC;
               end
               CMD_BACK:  state_in = S_CP_RD;
               CMD_CLEAR: state_in = S_FILL;
               CMD_READ:  state_in = bad_ff ? S_DONE : S_RD_ISSUE;
               default:   state_in = S_DONE;
            endcase
         end
         S_NL_DIV:   state_in = alu_ge ? S_NL_DIV : S_NL_ADD;
         S_NL_ADD:   state_in = S_NL_SUB;
         S_NL_SUB:   state_in = S_SCR_CHK;
         S_INC:      state_in = S_SCR_CHK;
         S_CP_RD:    state_in = S_CP_WR;
         S_CP_WR: begin
            if (cnt_last) begin
               case (cp_mode_ff)
                  CP_INS:    state_in = S_RD_ISSUE;
                  CP_SCROLL: state_in = S_FILL;
                  default:   state_in = S_SCR_CHK;
               endcase
            end else begin
               state_in = S_CP_RD;
            end
         end
         S_RD_ISSUE: state_in = S_RD_TAKE;
         S_RD_TAKE:  state_in = (cmd_ff == CMD_READ) ? S_DONE : S_INC;
         S_SCR_CHK:  state_in = alu_ge ? S_CP_RD : S_DONE;
         S_FILL: begin
            if (cnt_last) state_in = S_DONE;
         end
         S_DONE: begin
            if (rsp_free) state_in = S_IDLE;
         end
         default:    state_in = S_IDLE;
      endcase
   end

   // datapath, memory and adder control
   always_comb begin
      cmd_in        = cmd_ff;
      ch_in         = ch_ff;
      ins_in        = ins_ff;
      tail_in       = tail_ff;
      bad_in        = bad_ff;
      pos_in        = pos_ff;
      rem_in        = rem_ff;
      src_in        = src_ff;
      dst_in        = dst_ff;
      cnt_in        = cnt_ff;
      cursor_in     = cursor_ff;
      cp_mode_in    = cp_mode_ff;
      fill_mode_in  = fill_mode_ff;
      rd_char_in    = rd_char_ff;
      rd_attr_in    = rd_attr_ff;
      err_in        = err_ff;
      text_attr_in  = text_attr_ff;
      error_attr_in = error_attr_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_cursor_in = rsp_cursor_ff;
      rsp_char_in   = rsp_char_ff;
      rsp_attr_in   = rsp_attr_ff;
      rsp_err_in    = rsp_err_ff;
      ram_we        = 1'b0;
      ram_waddr     = dst_ff[AW-1:0];
      ram_wdata     = '0;
      ram_raddr     = src_ff[AW-1:0];
      alu_a         = pos_ff;
      alu_b         = ONE_P;
      alu_op        = ALU_ADD;

      if (csr_valid && csr_ready) begin
         if (csr_index == CSR_TEXT_ATTR) text_attr_in = csr_wdata;
         else if (csr_index == CSR_ERROR_ATTR) error_attr_in = csr_wdata;
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd_in     = cmd_type'(req_command);
               ch_in      = req_char_code;
               ins_in     = req_insert_mode;
               tail_in    = req_tail_len;
               bad_in     = bad_req;
               rd_char_in = '0;
               rd_attr_in = '0;
               err_in     = 1'b0;
               if (req_use_cursor) pos_in = PW'(cursor_ff);
               else if (bad_req) pos_in = '0;
               else pos_in = PW'(req_row) * COLS_P + PW'(req_col);
            end
         end
         S_DISPATCH: begin
            alu_a  = PW'(cursor_ff);
            alu_b  = ONE_P;
            alu_op = ALU_SUB;
            case (cmd_ff)
               CMD_WRITE: begin
                  if (bad_ff) begin
                     ram_we    = 1'b1;
                     ram_waddr = LAST_P[AW-1:0];
                     ram_wdata = {error_attr_ff, CHAR_E};
                     err_in    = 1'b1;
                  end else if (ch_ff == CHAR_NL) begin
                     rem_in = pos_ff;
                  end else if (ch_ff == CHAR_BS) begin
                     dst_in     = pos_ff;
                     src_in     = pos_ff + ONE_P;
                     cnt_in     = PW'(tail_ff) + ONE_P;
                     cp_mode_in = CP_DEL;
                  end else if (ins_ff) begin
                     src_in     = pos_ff + PW'(tail_ff);
                     dst_in     = pos_ff + PW'(tail_ff) + ONE_P;
                     cnt_in     = PW'(tail_ff) + ONE_P;
                     cp_mode_in = CP_INS;
                  end else begin
                     ram_we    = 1'b1;
                     ram_waddr = pos_ff[AW-1:0];
                     ram_wdata = {plain_attr, ch_ff};
                  end
               end
               CMD_BACK: begin
                  pos_in     = bs_pos;
                  dst_in     = bs_pos;
                  src_in     = bs_pos + ONE_P;
                  cnt_in     = PW'(tail_ff) + ONE_P;
                  cp_mode_in = CP_DEL;
               end
               CMD_LEFT: begin
                  if (alu_ge) cursor_in = alu_res[AW-1:0];
               end
               CMD_RIGHT: begin
                  if (cursor_ff != LAST_P[AW-1:0]) cursor_in = cursor_ff + AW'(1);
               end
               CMD_CLEAR: begin
                  dst_in       = '0;
                  cnt_in       = CELLS_P;
                  fill_mode_in = FL_CLEAR;
               end
               CMD_READ: begin
                  err_in = bad_ff;
               end
               default: begin
               end
            endcase
         end
         S_NL_DIV: begin
            alu_a  = rem_ff;
            alu_b  = COLS_P;
            alu_op = ALU_SUB;
            if (alu_ge) rem_in = alu_res;
         end
         S_NL_ADD: begin
            alu_a  = pos_ff;
            alu_b  = COLS_P;
            alu_op = ALU_ADD;
            pos_in = alu_res;
         end
         S_NL_SUB: begin
            alu_a  = pos_ff;
            alu_b  = rem_ff;
            alu_op = ALU_SUB;
            pos_in = alu_res;
         end
         S_INC: begin
            alu_a  = pos_ff;
            alu_b  = ONE_P;
            alu_op = ALU_ADD;
            pos_in = alu_res;
         end
         S_CP_WR: begin
            if (dst_ff < CELLS_P) begin
               ram_we    = 1'b1;
               ram_wdata = (src_ff < CELLS_P) ? ram_rdata : 16'h0000;
            end
            cnt_in = cnt_ff - ONE_P;
            if (cp_mode_ff == CP_INS) begin
               src_in = src_ff - ONE_P;
               dst_in = dst_ff - ONE_P;
            end else begin
               src_in = src_ff + ONE_P;
               dst_in = dst_ff + ONE_P;
            end
            if (cnt_last && cp_mode_ff == CP_SCROLL) begin
               dst_in       = SCR_BASE_P;
               cnt_in       = COLS_P;
               fill_mode_in = FL_ZERO;
            end
         end
         S_RD_ISSUE: begin
            ram_raddr = pos_ff[AW-1:0];
         end
         S_RD_TAKE: begin
            if (cmd_ff == CMD_READ) begin
               rd_char_in = ram_rdata[7:0];
               rd_attr_in = ram_rdata[15:8];
            end else begin
               ram_we    = 1'b1;
               ram_waddr = pos_ff[AW-1:0];
               ram_wdata = {ram_rdata[15:8], ch_ff};
            end
         end
         S_SCR_CHK: begin
            alu_a  = pos_ff;
            alu_b  = CELLS_P;
            alu_op = ALU_SUB;
            if (alu_ge) begin
               pos_in     = SCR_BASE_P;
               src_in     = COLS_P;
               dst_in     = '0;
               cnt_in     = SCR_LEN_P;
               cp_mode_in = CP_SCROLL;
            end else begin
               cursor_in = pos_ff[AW-1:0];
            end
         end
         S_FILL: begin
            ram_we    = 1'b1;
            ram_wdata = (fill_mode_ff == FL_CLEAR) ? {plain_attr, CHAR_SPACE} : 16'h0000;
            dst_in    = dst_ff + ONE_P;
            cnt_in    = cnt_ff - ONE_P;
            if (cnt_last) begin
               cursor_in = (fill_mode_ff == FL_CLEAR) ? '0 : pos_ff[AW-1:0];
            end
         end
         S_DONE: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_cursor_in = cursor_ff;
               rsp_char_in   = rd_char_ff;
               rsp_attr_in   = rd_attr_ff;
               rsp_err_in    = err_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         cursor_ff     <= '0;
         text_attr_ff  <= ATTR_DEFAULT;
         error_attr_ff <= ATTR_ERR_RST;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cursor_ff     <= cursor_in;
         text_attr_ff  <= text_attr_in;
         error_attr_ff <= error_attr_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      ch_ff         <= ch_in;
      ins_ff        <= ins_in;
      tail_ff       <= tail_in;
      bad_ff        <= bad_in;
      pos_ff        <= pos_in;
      rem_ff        <= rem_in;
      src_ff        <= src_in;
      dst_ff        <= dst_in;
      cnt_ff        <= cnt_in;
      cp_mode_ff    <= cp_mode_in;
      fill_mode_ff  <= fill_mode_in;
      rd_char_ff    <= rd_char_in;
      rd_attr_ff    <= rd_attr_in;
      err_ff        <= err_in;
      rsp_cursor_ff <= rsp_cursor_in;
      rsp_char_ff   <= rsp_char_in;
      rsp_attr_ff   <= rsp_attr_in;
      rsp_err_ff    <= rsp_err_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_cursor_pos  = rsp_cursor_ff;
   assign rsp_read_char   = rsp_char_ff;
   assign rsp_read_attr   = rsp_attr_ff;
   assign rsp_coord_error = rsp_err_ff;

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> state_ff == S_DISPATCH)
      else $error("accepted item did not start");

   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      int'(cursor_ff) < CELLS)
      else $error("cursor outside the screen");

   a_write_range: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> int'(ram_waddr) < CELLS)
      else $error("cell write outside the screen");

   a_done_result: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DONE && rsp_free |=> rsp_valid_ff && state_ff == S_IDLE)
      else $error("finished item produced no result");

   a_bad_no_move: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DISPATCH && bad_ff && cmd_ff == CMD_WRITE |=> $stable(cursor_ff))
      else $error("cursor moved on bad coordinates");

endmodule

// ===== rtl/tcw_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module tcw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/tcw_alu.sv =====
// Shared add/subtract unit with an unsigned greater-or-equal flag on subtract.
module tcw_alu import tcw_pkg::*; #(
   parameter int W = 12
) (
   input  logic [W-1:0] a,
   input  logic [W-1:0] b,
   input  alu_op_type   op,
   output logic [W-1:0] res,
   output logic         ge
);

   logic         sub;
   logic [W:0]   sum;

   assign sub = (op == ALU_SUB);
   assign sum = {1'b0, a} + {1'b0, (sub ? ~b : b)} + {{W{1'b0}}, sub};
   assign res = sum[W-1:0];
   // no borrow on subtract means a >= b
   assign ge  = sub & sum[W];

endmodule

// ===== sim/tb_text_console_cell_writer.sv =====
// Self-checking testbench for the text console cell writer.
`timescale 1ns / 1ps

module tb;
   import tcw_pkg::*;

   localparam int ROWS   = 25;
   localparam int COLS   = 80;
   localparam int CELLS  = ROWS * COLS;
   localparam int CELL_W = $clog2(CELLS);

   localparam logic [2:0] CMD_SPARE_A = 3'd6;
   localparam logic [2:0] CMD_SPARE_B = 3'd7;

   typedef struct packed {
      logic [2:0] command;
      logic [7:0] char_code;
      logic [7:0] col;
      logic [7:0] row;
      logic       use_cursor;
      logic       insert_mode;
      logic [7:0] tail_len;
   } console_req_type;

   typedef struct packed {
      logic [CELL_W-1:0] cursor_pos;
      logic [7:0]        read_char;
      logic [7:0]        read_attr;
      logic              coord_error;
   } console_rsp_type;

   logic                 clock;
   logic                 reset           = 1'b1;
   logic                 req_valid       = 1'b0;
   logic                 req_stall;
   logic [2:0]           req_command     = '0;
   logic [7:0]           req_char_code   = '0;
   logic [7:0]           req_col         = '0;
   logic [7:0]           req_row         = '0;
   logic                 req_use_cursor  = 1'b0;
   logic                 req_insert_mode = 1'b0;
   logic [7:0]           req_tail_len    = '0;
   logic                 rsp_valid;
   logic                 rsp_stall       = 1'b0;
   logic [CELL_W-1:0]    rsp_cursor_pos;
   logic [7:0]           rsp_read_char;
   logic [7:0]           rsp_read_attr;
   logic                 rsp_coord_error;
   logic                 csr_valid       = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index       = '0;
   logic [7:0]           csr_wdata       = '0;

   // screen model
   logic [15:0]  screen_cells [CELLS];
   int unsigned  cursor_cell  = 0;
   logic [7:0]   text_attr_q  = ATTR_DEFAULT;
   logic [7:0]   error_attr_q = ATTR_ERR_RST;

   console_rsp_type rsp_due [$];
   int              error_count   = 0;
   int              send_idle_pct = 0;
   int              rsp_idle_pct  = 0;

   text_console_cell_writer #(.ROWS(ROWS), .COLS(COLS)) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_command     (req_command),
      .req_char_code   (req_char_code),
      .req_col         (req_col),
      .req_row         (req_row),
      .req_use_cursor  (req_use_cursor),
      .req_insert_mode (req_insert_mode),
      .req_tail_len    (req_tail_len),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_cursor_pos  (rsp_cursor_pos),
      .rsp_read_char   (rsp_read_char),
      .rsp_read_attr   (rsp_read_attr),
      .rsp_coord_error (rsp_coord_error),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #200_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   task automatic report_mismatch(input string what);
      $display("MISMATCH @%0t: %s", $time, what);
      error_count++;
   endtask

   // delete at p: cells p..p+n take their right neighbor, zero past the end
   function automatic void erase_cell(input int unsigned p, input int unsigned n);
      int unsigned k;
      for (k = 0; k <= n && p + k < CELLS; k++)
         screen_cells[p + k] = (p + k + 1 < CELLS) ? screen_cells[p + k + 1] : 16'h0000;
   endfunction

   function automatic console_rsp_type apply_console_cmd(input console_req_type r);
      console_rsp_type o;
      int unsigned     pos;
      int unsigned     k;
      logic            bad;
      logic [7:0]      pattr;
      o     = '0;
      bad   = !r.use_cursor && (r.col >= COLS || r.row >= ROWS);
      pattr = (text_attr_q != 8'h00) ? text_attr_q : ATTR_DEFAULT;
      pos   = r.use_cursor ? cursor_cell : (bad ? 0 : r.row * COLS + r.col);
      case (r.command)
         CMD_WRITE: begin
            if (bad) begin
               screen_cells[CELLS - 1] = {error_attr_q, CHAR_E};
               o.coord_error = 1'b1;
            end else begin
               if (r.char_code == CHAR_NL) begin
                  pos = (pos / COLS + 1) * COLS;
               end else if (r.char_code == CHAR_BS) begin
                  erase_cell(pos, r.tail_len);
               end else begin
                  if (r.insert_mode) begin
                     for (k = r.tail_len + 1; k > 0; k--)
                        if (pos + k < CELLS)
                           screen_cells[pos + k] = screen_cells[pos + k - 1];
                     screen_cells[pos][7:0] = r.char_code;
                  end else begin
                     screen_cells[pos] = {pattr, r.char_code};
                  end
                  pos++;
               end
               if (pos >= CELLS) begin
                  for (k = 0; k < CELLS - COLS; k++)
                     screen_cells[k] = screen_cells[k + COLS];
                  for (k = CELLS - COLS; k < CELLS; k++)
                     screen_cells[k] = 16'h0000;
                  pos -= COLS;
               end
               cursor_cell = pos;
            end
         end
         CMD_BACK: begin
            pos = (cursor_cell > 0) ? cursor_cell - 1 : 0;
            erase_cell(pos, r.tail_len);
            cursor_cell = pos;
         end
         CMD_LEFT: begin
            if (cursor_cell > 0)
               cursor_cell--;
         end
         CMD_RIGHT: begin
            if (cursor_cell + 1 < CELLS)
               cursor_cell++;
         end
         CMD_CLEAR: begin
            for (k = 0; k < CELLS; k++)
               screen_cells[k] = {pattr, CHAR_SPACE};
            cursor_cell = 0;
         end
         CMD_READ: begin
            if (bad) begin
               o.coord_error = 1'b1;
            end else begin
               o.read_char = screen_cells[pos][7:0];
               o.read_attr = screen_cells[pos][15:8];
            end
         end
         default: ;
      endcase
      o.cursor_pos = cursor_cell[CELL_W-1:0];
      return o;
   endfunction

   function automatic console_req_type make_req(input logic [2:0] command,
                                                input logic [7:0] char_code,
                                                input logic [7:0] col,
                                                input logic [7:0] row,
                                                input logic use_cursor,
                                                input logic insert_mode,
                                                input logic [7:0] tail_len);
      console_req_type r;
      r.command     = command;
      r.char_code   = char_code;
      r.col         = col;
      r.row         = row;
      r.use_cursor  = use_cursor;
      r.insert_mode = insert_mode;
      r.tail_len    = tail_len;
      return r;
   endfunction

   function automatic console_req_type on_screen(input console_req_type r);
      r.use_cursor = 1'b0;
      r.col        = 8'($urandom_range(0, COLS - 1));
      r.row        = 8'($urandom_range(0, ROWS - 1));
      return r;
   endfunction

   function automatic console_req_type off_screen(input console_req_type r);
      r.use_cursor = 1'b0;
      if ($urandom_range(0, 1))
         r.col = 8'($urandom_range(COLS, 255));
      else
         r.row = 8'($urandom_range(ROWS, 255));
      return r;
   endfunction

   function automatic console_req_type rand_req();
      console_req_type r;
      int unsigned     pick;
      r.command     = CMD_WRITE;
      r.char_code   = 8'($urandom);
      r.col         = 8'($urandom);
      r.row         = 8'($urandom);
      r.use_cursor  = 1'b1;
      r.insert_mode = ($urandom_range(0, 3) == 0);
      r.tail_len    = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 6));
      pick = $urandom_range(0, 199);
      if (pick < 30) begin
         r = on_screen(r);
         if (pick < 8)
            r.row = 8'(ROWS - 1);
      end else if (pick < 42) begin
         r.char_code = CHAR_NL;
      end else if (pick < 50) begin
         r.char_code = CHAR_BS;
         if (pick < 46)
            r = on_screen(r);
      end else if (pick < 66) begin
         r.command    = CMD_BACK;
         r.use_cursor = 1'($urandom);
      end else if (pick < 78) begin
         r.command    = CMD_LEFT;
         r.use_cursor = 1'($urandom);
      end else if (pick < 90) begin
         r.command    = CMD_RIGHT;
         r.use_cursor = 1'($urandom);
      end else if (pick < 110) begin
         r.command = CMD_READ;
         r = on_screen(r);
      end else if (pick < 118) begin
         r.command = CMD_READ;
      end else if (pick < 123) begin
         r = off_screen(r);
      end else if (pick < 126) begin
         r.command = CMD_READ;
         r = off_screen(r);
      end else if (pick < 127) begin
         r.command    = CMD_CLEAR;
         r.use_cursor = 1'($urandom);
      end else if (pick < 130) begin
         r.command    = $urandom_range(0, 1) ? CMD_SPARE_A : CMD_SPARE_B;
         r.use_cursor = 1'($urandom);
      end
      return r;
   endfunction

   task automatic send_item(input console_req_type r);
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_command     <= r.command;
      req_char_code   <= r.char_code;
      req_col         <= r.col;
      req_row         <= r.row;
      req_use_cursor  <= r.use_cursor;
      req_insert_mode <= r.insert_mode;
      req_tail_len    <= r.tail_len;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      rsp_due.push_back(apply_console_cmd(r));
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      do
         @(posedge clock);
      while (rsp_due.size() != 0);
   endtask

   // writes both attribute registers back to back; block must be idle
   task automatic set_attrs(input logic [7:0] text_attr, input logic [7:0] error_attr);
      drain_results();
      csr_valid <= 1'b1;
      csr_index <= CSR_TEXT_ATTR;
      csr_wdata <= text_attr;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      text_attr_q = text_attr;
      csr_index <= CSR_ERROR_ATTR;
      csr_wdata <= error_attr;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      error_attr_q = error_attr;
      csr_valid <= 1'b0;
   endtask

   always @(posedge clock) begin : rsp_check
      console_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (rsp_due.size() == 0) begin
            report_mismatch($sformatf("result with nothing pending, cursor %0d",
                                      rsp_cursor_pos));
         end else begin
            want = rsp_due.pop_front();
            if (rsp_cursor_pos !== want.cursor_pos)
               report_mismatch($sformatf("cursor_pos got %0d want %0d",
                                         rsp_cursor_pos, want.cursor_pos));
            if (rsp_read_char !== want.read_char)
               report_mismatch($sformatf("read_char got %0h want %0h",
                                         rsp_read_char, want.read_char));
            if (rsp_read_attr !== want.read_attr)
               report_mismatch($sformatf("read_attr got %0h want %0h",
                                         rsp_read_attr, want.read_attr));
            if (rsp_coord_error !== want.coord_error)
               report_mismatch($sformatf("coord_error got %0b want %0b",
                                         rsp_coord_error, want.coord_error));
         end
      end
      rsp_stall <= ($urandom_range(0, 99) < rsp_idle_pct);
   end

   task automatic test_directed_edits();
      send_item(make_req(CMD_CLEAR, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0, 8'h00));
      send_item(make_req(CMD_READ, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00));
      send_item(make_req(CMD_WRITE, "A", 8'h00, 8'h00, 1'b1, 1'b0, 8'h00));
      send_item(make_req(CMD_WRITE, 8'hFF, 8'(COLS - 2), 8'(ROWS - 1), 1'b0, 1'b0, 8'h00));
      send_item(make_req(CMD_RIGHT, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0, 8'h00));
      // past the last cell: scroll
      send_item(make_req(CMD_WRITE, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0, 8'h00));
      send_item(make_req(CMD_READ, 8'h00, 8'(COLS - 2), 8'(ROWS - 2), 1'b0, 1'b0, 8'h00));
      send_item(make_req(CMD_WRITE, "x", 8'(COLS), 8'h00, 1'b0, 1'b0, 8'h00));
      send_item(make_req(CMD_READ, 8'h00, 8'(COLS - 1), 8'(ROWS - 1), 1'b0, 1'b0, 8'h00));
      send_item(make_req(CMD_READ, 8'h00, 8'hFF, 8'hFF, 1'b0, 1'b0, 8'h00));
      send_item(make_req(CMD_WRITE, CHAR_NL, 8'h00, 8'h00, 1'b1, 1'b0, 8'h00));
      send_item(make_req(CMD_WRITE, "B", 8'h00, 8'h00, 1'b0, 1'b1, 8'h03));
      send_item(make_req(CMD_WRITE, "C", 8'(COLS - 8), 8'(ROWS - 1), 1'b0, 1'b1, 8'hFF));
      send_item(make_req(CMD_WRITE, CHAR_BS, 8'h00, 8'h00, 1'b0, 1'b0, 8'hFF));
      send_item(make_req(CMD_WRITE, CHAR_BS, 8'(COLS - 1), 8'(ROWS - 1), 1'b0, 1'b0, 8'h05));
      send_item(make_req(CMD_WRITE, "D", 8'h00, 8'h00, 1'b0, 1'b0, 8'h00));
      send_item(make_req(CMD_BACK, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0, 8'h00));
      // backspace at cell zero
      send_item(make_req(CMD_BACK, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0, 8'h02));
      send_item(make_req(CMD_LEFT, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0, 8'h00));
      send_item(make_req(CMD_RIGHT, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0, 8'h00));
      send_item(make_req(CMD_SPARE_A, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00));
      send_item(make_req(CMD_SPARE_B, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1, 8'hFF));
      send_item(make_req(CMD_READ, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1, 8'hFF));
      send_item(make_req(CMD_WRITE, "q", 8'h00, 8'(ROWS), 1'b0, 1'b1, 8'h04));
      send_item(make_req(CMD_WRITE, CHAR_NL, 8'd40, 8'd3, 1'b0, 1'b0, 8'h00));
   endtask

   task automatic probe_attrs();
      send_item(make_req(CMD_CLEAR, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0, 8'h00));
      send_item(make_req(CMD_READ, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00));
      send_item(make_req(CMD_WRITE, "Z", 8'd1, 8'd1, 1'b0, 1'b0, 8'h00));
      send_item(make_req(CMD_READ, 8'h00, 8'd1, 8'd1, 1'b0, 1'b0, 8'h00));
      send_item(make_req(CMD_WRITE, "Z", 8'hFF, 8'h00, 1'b0, 1'b0, 8'h00));
      send_item(make_req(CMD_READ, 8'h00, 8'(COLS - 1), 8'(ROWS - 1), 1'b0, 1'b0, 8'h00));
   endtask

   task automatic test_attr_registers();
      // zero text attribute falls back to the default
      set_attrs(8'h00, 8'h00);
      probe_attrs();
      set_attrs(8'hFF, 8'hFF);
      probe_attrs();
      set_attrs(ATTR_DEFAULT, ATTR_ERR_RST);
   endtask

   task automatic test_random_traffic(input int count);
      int i;
      set_attrs(8'($urandom), 8'($urandom));
      for (i = 0; i < count; i++) begin
         if (i == count / 2)
            drain_results();
         send_item(rand_req());
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      send_idle_pct = 26;
      rsp_idle_pct  = 78;
      test_directed_edits();
      test_attr_registers();
      test_random_traffic(600);
      send_idle_pct = 78;
      rsp_idle_pct  = 26;
      test_random_traffic(600);
      send_idle_pct = 0;
      rsp_idle_pct  = 0;
      test_random_traffic(600);
      drain_results();
      repeat (32) @(posedge clock);
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
